/* hw/rtl/rsfp_pkg.sv */
package rsfp_pkg;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [13:0] CYCLE_END    = 14'd10980;
    localparam logic [13:0] HOLD1_START  = 14'd1830;
    localparam logic [13:0] RAMP2_START  = 14'd3660;
    localparam logic [13:0] HOLD2_START  = 14'd5490;
    localparam logic [13:0] RAMPDN_START = 14'd7320;

    localparam logic [9:0] HOLD1_LEVEL = 10'd457;
    localparam logic [9:0] HOLD2_LEVEL = 10'd917;
    localparam logic [9:0] RAMP_OFFSET = 10'd150;
    // The ramp-down numerator carries 20 extra divisors so it never goes negative.
    localparam logic [9:0] RAMPDN_OFFSET = 10'd130;

    localparam logic [21:0] UP1_GAIN = 22'd307;
    localparam logic [21:0] UP2_GAIN = 22'd460;
    localparam logic [21:0] UP2_BIAS = 22'd1121790;
    localparam logic [21:0] DN_GAIN  = 22'd767;
    localparam logic [23:0] DN_BIAS  = 24'd8425200;

    // Reciprocals: 2^32 / 1830 and 2^34 / 3570, rounded up.
    localparam logic [22:0] RECIP_1830 = 23'd2346977;
    localparam logic [22:0] RECIP_3570 = 23'd4812289;

    // Reciprocal of ten as 2^14 / 10, rounded up.
    localparam logic [10:0] RECIP_10 = 11'd1639;
    localparam logic [11:0] ROUND_UP_10 = 12'd9;

    typedef enum logic [2:0] {
        SEG_KEEP,
        SEG_RAMP1,
        SEG_HOLD1,
        SEG_RAMP2,
        SEG_HOLD2,
        SEG_RAMPDN
    } seg_t;

    typedef struct packed {
        seg_t        seg;
        logic [21:0] numer;
        logic        active;
        logic        done;
        logic [7:0]  light_led;
        logic [9:0]  temp_led;
        logic [7:0]  comp;
    } stage1_t;

    typedef struct packed {
        seg_t        seg;
        logic [9:0]  quot;
        logic        active;
        logic        done;
        logic [7:0]  light_led;
        logic [9:0]  temp_led;
        logic [7:0]  comp;
    } stage2_t;

    typedef struct packed {
        logic [9:0] profile_value;
        logic [9:0] fan_duty;
        logic [7:0] fan_duty_low;
        logic [7:0] light_led;
        logic [9:0] temp_led;
        logic       running;
        logic       cycle_done;
    } result_t;

endpackage

/* hw/rtl/ramp_soak_fan_profile_top.sv */
// Channel   Direction  Request contents
// s_        in         tuser: kind; tdata: light_sample, temp_sample
// m_        out        tdata: profile_value .. temp_led; tuser: running; tlast: cycle_done
//
// One request is taken per cycle unless the output stalls; its result passes the
// control, division and output registers. The reciprocal multiply for the profile
// division has its own stage between the state update and the duty computation.
// Reset clears the counter, setpoint, cycle flag, sample holds and all valid bits.
// A stalled result holds each stage; a stage takes a new request when it is
// empty or the stage after it moves on.
module ramp_soak_fan_profile_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // light_sample, temp_sample
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // profile_value, fan_duty, fan_duty_low, light_led, temp_led
    output logic [0:0]  m_tuser,   // running
    output logic        m_tlast
);
    import rsfp_pkg::*;

    logic    st1_valid, st1_ready;
    stage1_t st1_data;
    logic    st2_valid, st2_ready;
    stage2_t st2_data;
    result_t result;

    rsfp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_light  (s_tdata[9:0]),
        .in_temp   (s_tdata[19:10]),
        .out_valid (st1_valid),
        .out_ready (st1_ready),
        .out_data  (st1_data)
    );

    rsfp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st1_valid),
        .in_ready  (st1_ready),
        .in_data   (st1_data),
        .out_valid (st2_valid),
        .out_ready (st2_ready),
        .out_data  (st2_data)
    );

    rsfp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st2_valid),
        .in_ready  (st2_ready),
        .in_data   (st2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {2'b00, result.temp_led, result.light_led, result.fan_duty_low,
                      result.fan_duty, result.profile_value};
    assign m_tuser = result.running;
    assign m_tlast = result.cycle_done;

endmodule

/* hw/rtl/rsfp_ctrl.sv */
module rsfp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_kind,
    input  logic [9:0]           in_light,
    input  logic [9:0]           in_temp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsfp_pkg::stage1_t    out_data
);
    import rsfp_pkg::*;

    logic [13:0] tick_count_reg, tick_count_next;
    logic        active_reg, active_next;
    logic [7:0]  light_low_reg, light_low_next;
    logic [9:0]  temp_hold_reg, temp_hold_next;
    logic [7:0]  comp_reg, comp_next;
    logic        valid_reg;
    stage1_t     data_reg, data_next;

    logic [13:0] count_inc;
    logic [10:0] sample_sum;
    logic [11:0] sum_round;
    logic [22:0] comp_prod;
    logic        done;
    seg_t        seg;
    logic [21:0] numer_up1, numer_up2, numer_dn;
    logic        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    assign count_inc = tick_count_reg + 14'd1;
    assign sample_sum = {1'b0, in_light} + {1'b0, in_temp};
    assign sum_round = {1'b0, sample_sum} + ROUND_UP_10;
    assign comp_prod = {11'b0, sum_round} * {12'b0, RECIP_10};

    assign numer_up1 = 22'(count_inc) * UP1_GAIN;
    assign numer_up2 = 22'(count_inc) * UP2_GAIN - UP2_BIAS;
    assign numer_dn = 22'(DN_BIAS - 24'(count_inc) * 24'(DN_GAIN));

    always_comb begin
        tick_count_next = tick_count_reg;
        active_next = active_reg;
        light_low_next = light_low_reg;
        temp_hold_next = temp_hold_reg;
        comp_next = comp_reg;
        done = 1'b0;
        seg = SEG_KEEP;
        case (in_kind)
            KIND_TICK: begin
                if (count_inc >= CYCLE_END) begin
                    tick_count_next = '0;
                    active_next = 1'b0;
                    done = 1'b1;
                end else begin
                    tick_count_next = count_inc;
                    if (count_inc < HOLD1_START) begin
                        seg = SEG_RAMP1;
                    end else if (count_inc < RAMP2_START) begin
                        seg = SEG_HOLD1;
                    end else if (count_inc < HOLD2_START) begin
                        seg = SEG_RAMP2;
                    end else if (count_inc < RAMPDN_START) begin
                        seg = SEG_HOLD2;
                    end else begin
                        seg = SEG_RAMPDN;
                    end
                end
            end
            KIND_START: begin
                if (!active_reg) begin
                    tick_count_next = '0;
                    active_next = 1'b1;
                end
            end
            KIND_SAMPLE: begin
                if (active_reg) begin
                    light_low_next = in_light[7:0];
                    temp_hold_next = in_temp;
                    comp_next = comp_prod[21:14];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        data_next.seg = seg;
        case (seg)
            SEG_RAMP1:  data_next.numer = numer_up1;
            SEG_RAMP2:  data_next.numer = numer_up2;
            SEG_RAMPDN: data_next.numer = numer_dn;
            default:    data_next.numer = '0;
        endcase
        data_next.active = active_next;
        data_next.done = done;
        data_next.light_led = active_next ? light_low_next : 8'd0;
        data_next.temp_led = active_next ? temp_hold_next : 10'd0;
        data_next.comp = comp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            active_reg <= 1'b0;
            light_low_reg <= '0;
            temp_hold_reg <= '0;
            comp_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                tick_count_reg <= tick_count_next;
                active_reg <= active_next;
                light_low_reg <= light_low_next;
                temp_hold_reg <= temp_hold_next;
                comp_reg <= comp_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/rsfp_div.sv */
module rsfp_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsfp_pkg::stage1_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsfp_pkg::stage2_t    out_data
);
    import rsfp_pkg::*;

    logic        valid_reg;
    stage2_t     data_reg, data_next;
    logic [22:0] recip;
    logic [44:0] prod;
    logic        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    assign recip = (in_data.seg == SEG_RAMPDN) ? RECIP_3570 : RECIP_1830;
    assign prod = {23'b0, in_data.numer} * {22'b0, recip};

    always_comb begin
        data_next.seg = in_data.seg;
        data_next.quot = (in_data.seg == SEG_RAMPDN) ? prod[43:34] : prod[41:32];
        data_next.active = in_data.active;
        data_next.done = in_data.done;
        data_next.light_led = in_data.light_led;
        data_next.temp_led = in_data.temp_led;
        data_next.comp = in_data.comp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/rsfp_out.sv */
module rsfp_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsfp_pkg::stage2_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsfp_pkg::result_t    out_data
);
    import rsfp_pkg::*;

    logic        valid_reg;
    logic [9:0]  profile_reg, profile_next;
    result_t     data_reg, data_next;
    logic [10:0] duty_diff;
    logic [9:0]  duty;
    logic        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb begin
        case (in_data.seg)
            SEG_RAMP1,
            SEG_RAMP2:  profile_next = in_data.quot + RAMP_OFFSET;
            SEG_HOLD1:  profile_next = HOLD1_LEVEL;
            SEG_HOLD2:  profile_next = HOLD2_LEVEL;
            SEG_RAMPDN: profile_next = in_data.quot + RAMPDN_OFFSET;
            default:    profile_next = profile_reg;
        endcase
    end

    // Duty is setpoint less ceil(sample sum/10), zero if negative or idle.
    assign duty_diff = {1'b0, profile_next} - {3'b0, in_data.comp};
    assign duty = (!in_data.active || duty_diff[10]) ? 10'd0 : duty_diff[9:0];

    always_comb begin
        data_next.profile_value = profile_next;
        data_next.fan_duty = duty;
        data_next.fan_duty_low = duty[7:0];
        data_next.light_led = in_data.light_led;
        data_next.temp_led = in_data.temp_led;
        data_next.running = in_data.active;
        data_next.cycle_done = in_data.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            profile_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                profile_reg <= profile_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule
